// ===== rtl/core/lpmac_pkg.sv =====
// Package: payload types, AES tables and helpers for the length-prefixed CBC-MAC.
`default_nettype none
package lpmac_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned AesRounds  = 10;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_e;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] message_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic        start;      // load length block and encrypt
    logic        empty_msg;  // start with zero length: emit after encrypt
    logic [15:0] length;
    logic [7:0]  data;
    logic [3:0]  pos;        // byte position in chaining block
    logic        encrypt;    // encrypt after this byte
    logic        emit;       // emit MAC after encrypt
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits at bits 127-8i .. 120-8i.
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
    return b[127-8*i -: 8];
  endfunction

  // One round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] x0, x1, x2, x3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[c*4+i] = sbox(blk_byte(s, ((c + i) % 4) * 4 + i));
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        x0 = t[c*4]; x1 = t[c*4+1]; x2 = t[c*4+2]; x3 = t[c*4+3];
        all = x0 ^ x1 ^ x2 ^ x3;
        t[c*4]   = x0 ^ all ^ xt(x0 ^ x1);
        t[c*4+1] = x1 ^ all ^ xt(x1 ^ x2);
        t[c*4+2] = x2 ^ all ^ xt(x2 ^ x3);
        t[c*4+3] = x3 ^ all ^ xt(x3 ^ x0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r ^ rk;
  endfunction

  // Next round key from the current one.
  function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lpmac_front.sv =====
// Front end: tracks message length and position, classifies words into commands.
`default_nettype none
module lpmac_front import lpmac_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_data_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output cmd_t          cmd_o,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i
);

  logic [15:0] left_q, left_d;
  logic [3:0]  pos_q, pos_d;
  logic        open_q, open_d;
  logic        acc;
  logic [15:0] left_m1;

  assign in_ready_o = cmd_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign left_m1 = left_q - 16'd1;

  always_comb begin
    cmd_o = '0;
    cmd_o.length = in_data_i.message_length;
    cmd_o.data = in_data_i.data_byte;
    cmd_o.pos = pos_q;
    cmd_valid_o = 1'b0;
    left_d = left_q;
    pos_d = pos_q;
    open_d = open_q;
    if (in_valid_i) begin
      if (in_data_i.opcode == OP_START) begin
        cmd_valid_o = 1'b1;
        cmd_o.start = 1'b1;
        cmd_o.empty_msg = (in_data_i.message_length == 16'd0);
        left_d = in_data_i.message_length;
        pos_d = 4'd0;
        open_d = (in_data_i.message_length != 16'd0);
      end else if (open_q) begin
        // drop bytes outside a message
        cmd_valid_o = 1'b1;
        cmd_o.encrypt = (pos_q == 4'(BlockBytes - 1)) || (left_m1 == 16'd0);
        cmd_o.emit = (left_m1 == 16'd0);
        left_d = left_m1;
        pos_d = cmd_o.encrypt ? 4'd0 : pos_q + 4'd1;
        open_d = (left_m1 != 16'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      pos_q <= '0;
      open_q <= 1'b0;
    end else if (acc) begin
      left_q <= left_d;
      pos_q <= pos_d;
      open_q <= open_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> left_q != 16'd0) else $error("open message with no bytes left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_o.emit |-> cmd_o.encrypt) else $error("emit without encrypt");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> pos_q == 4'd0) else $error("position not cleared");

endmodule
`default_nettype wire

// ===== rtl/core/lpmac_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none
module lpmac_queue import lpmac_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t wr_data_i,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  output cmd_t      rd_data_o,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i
);

  cmd_t mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 3'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth)) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 3'd1) else $error("count not advanced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wp_q == rp_q) else $error("pointers diverged on empty");

endmodule
`default_nettype wire

// ===== rtl/core/lpmac_back.sv =====
// Back end: chaining block, iterative AES-128 core, MAC output register.
`default_nettype none
module lpmac_back import lpmac_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire logic [127:0] key_i,
  output out_item_t        out_data_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  state_e        state_q;
  logic [127:0]  chain_q, rk_q;
  logic [7:0]    rc_q;
  logic [3:0]    rnd_q;
  logic          emit_q;
  logic          out_valid_q;
  out_item_t     out_q;
  logic [127:0]  load_blk, nxt_rk, rnd_out;
  logic          take;

  // take commands only in idle; an emit waits for the output in ST_EMIT
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take = cmd_valid_i && cmd_ready_o;
  assign out_data_o = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    if (cmd_i.start) begin
      load_blk = '0;
      load_blk[127:120] = cmd_i.length[7:0];
      load_blk[119:112] = cmd_i.length[15:8];
    end else begin
      load_blk = chain_q;
      load_blk[127 - 8*cmd_i.pos -: 8] = chain_q[127 - 8*cmd_i.pos -: 8] ^ cmd_i.data;
    end
  end

  assign nxt_rk = key_expand(rk_q, rc_q);
  assign rnd_out = aes_round(chain_q, nxt_rk, rnd_q != 4'(AesRounds));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= '0;
      rk_q <= '0;
      rc_q <= 8'h01;
      rnd_q <= '0;
      emit_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (cmd_i.start || cmd_i.encrypt) begin
              chain_q <= load_blk ^ key_i;
              rk_q <= key_i;
              rc_q <= 8'h01;
              rnd_q <= 4'd1;
              emit_q <= cmd_i.start ? cmd_i.empty_msg : cmd_i.emit;
              state_q <= ST_RUN;
            end else begin
              chain_q <= load_blk;
            end
          end
        end
        ST_RUN: begin
          chain_q <= rnd_out;
          rk_q <= nxt_rk;
          rc_q <= xt(rc_q);
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'(AesRounds)) state_q <= emit_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q.mac_high <= chain_q[127:64];
            out_q.mac_low <= chain_q[63:0];
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> rnd_q >= 4'd1 && rnd_q <= 4'(AesRounds))
    else $error("round counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("MAC not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT) else $error("stray MAC");

endmodule
`default_nettype wire

// ===== rtl/core/length_prefixed_aes_cbc_mac_core.sv =====
// Top level of the length-prefixed AES-128 CBC-MAC core.
//
// Input channel: words of opcode/message_length/data_byte with valid/ready.
// A start word opens a message; data words fold one byte each into the
// chaining block. Output channel: one 128-bit MAC per message, valid/ready.
// Key is written over the APB port (key_high at 0x0, key_low at 0x8); the
// user must write it only while the core is idle, as it is not enforced.
// A front end classifies words into a four-entry queue; a back end runs an
// iterative AES core, one round per cycle. Bytes that do not close a
// block are folded in while the back end is idle, so a message sustains
// one byte per cycle apart from the encryption after the start word and
// after each 16th and final byte, which the queue partly absorbs.
// The MAC enters the output register from the emit state after encryption.
// A stalled receiver holds the MAC register; the next MAC then waits in
// the back end, which in turn fills the queue and drops in_ready_o.
// Reset clears key, chaining block, message state and queue.
`default_nettype none
module length_prefixed_aes_cbc_mac_core import lpmac_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_item_t    in_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output out_item_t        out_data_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] key_high_q, key_low_q;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3] ? REG_KEY_LOW : REG_KEY_HIGH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LOW:  key_low_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LOW:  prdata = key_low_q;
      default:      prdata = '0;
    endcase
  end

  lpmac_front u_front (
    .clk_i, .rst_ni,
    .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(f_cmd), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready)
  );

  lpmac_queue u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(f_cmd), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(q_cmd), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  lpmac_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(q_cmd), .cmd_valid_i(q_valid), .cmd_ready_o(q_ready),
    .key_i({key_high_q, key_low_q}),
    .out_data_o, .out_valid_o, .out_ready_i
  );

endmodule
`default_nettype wire
